@@ rtl/core/gtlr_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and the tile key function for the lru tile residency block
// no dependencies

package gtlr_pkg;

  localparam int KEY_W        = 17;
  localparam int CNT_OUT_W    = 5;
  localparam int LAT_W        = 8;
  localparam int LON_W        = 9;
  localparam int OP_W         = 2;
  localparam int CAPACITY_DEF = 16;

  localparam logic [CNT_OUT_W-1:0] MAX_TILES_RST = 5'd16;

  localparam logic signed [LAT_W-1:0] LAT_LO = -8'sd90;
  localparam logic signed [LAT_W-1:0] LAT_HI = 8'sd89;
  localparam logic signed [LON_W-1:0] LON_LO = -9'sd180;
  localparam logic signed [LON_W-1:0] LON_HI = 9'sd179;

  localparam logic [LAT_W-1:0] LAT_OFS  = 8'd90;
  localparam logic [LON_W-1:0] LON_OFS  = 9'd180;
  localparam logic [KEY_W-1:0] KEY_BASE = 17'd1001;
  localparam logic [KEY_W-1:0] ROW_LEN  = 17'd360;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_TRIM   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EVICT,
    ST_FINAL
  } state_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic mark_en;
    logic shift;
    logic shift_all;
  } cell_ctl_t;

  typedef struct packed {
    logic [KEY_W-1:0]     tile_key;
    logic                 hit;
    logic                 stored;
    logic                 evicted_valid;
    logic [KEY_W-1:0]     evicted_key;
    logic [CNT_OUT_W-1:0] resident_count;
    logic                 last;
  } rsp_t;

  // clamp to the tile grid and form the key
  function automatic logic [KEY_W-1:0] tile_key_of(input logic signed [LAT_W-1:0] lat,
                                                   input logic signed [LON_W-1:0] lon);
    logic signed [LAT_W-1:0] la;
    logic signed [LON_W-1:0] lo;
    logic [LAT_W-1:0]        la_off;
    logic [LON_W-1:0]        lo_off;
    la = lat;
    lo = lon;
    if (lat < LAT_LO) la = LAT_LO;
    if (lat > LAT_HI) la = LAT_HI;
    if (lon < LON_LO) lo = LON_LO;
    if (lon > LON_HI) lo = LON_HI;
    la_off = $unsigned(la) + LAT_OFS;
    lo_off = $unsigned(lo) + LON_OFS;
    return KEY_BASE + KEY_W'(lo_off) + KEY_W'(la_off) * ROW_LEN;
  endfunction

endpackage

@@ rtl/core/gtlr_if.sv @@
`timescale 1ns / 1ps
// request, response and register write channels of the lru tile residency block
// depends on gtlr_pkg

interface gtlr_req_if;
  import gtlr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic signed [LAT_W-1:0] lat_deg;
  logic signed [LON_W-1:0] lon_deg;
  logic                    source_ok;
  logic [KEY_W-1:0]        query_key;
  modport source (output valid, operation, lat_deg, lon_deg, source_ok, query_key,
                  input ready);
  modport sink (input valid, operation, lat_deg, lon_deg, source_ok, query_key,
                output ready);
endinterface

interface gtlr_rsp_if;
  import gtlr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [KEY_W-1:0]     tile_key;
  logic                 hit;
  logic                 stored;
  logic                 evicted_valid;
  logic [KEY_W-1:0]     evicted_key;
  logic [CNT_OUT_W-1:0] resident_count;
  logic                 last;
  modport source (output valid, tile_key, hit, stored, evicted_valid, evicted_key,
                  resident_count, last, input ready);
  modport sink (input valid, tile_key, hit, stored, evicted_valid, evicted_key,
                resident_count, last, output ready);
endinterface

interface gtlr_cfg_if;
  import gtlr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CNT_OUT_W-1:0] max_tiles;
  modport source (output valid, max_tiles, input ready);
  modport sink (input valid, max_tiles, output ready);
endinterface

@@ rtl/core/geo_tile_lru_residency.sv @@
`timescale 1ns / 1ps
// flow: idle takes the request beat, search runs the key search over the cell chain,
//   then evict or final registers the result beats, waiting while rsp.ready holds a beat
// no request is taken until the last beat is registered; n evicted tiles give n beats,
//   each with its evicted key (n >= 1), and any other request gives a single final beat
// an op code of 3 is taken and dropped in the same cycle
// reset: residency empty, max_tiles 16, no response pending; keys need no clearing

module geo_tile_lru_residency #(
  parameter int CAPACITY = gtlr_pkg::CAPACITY_DEF
) (
  input logic        clk,
  input logic        rst,
  gtlr_req_if.sink   req,
  gtlr_rsp_if.source rsp,
  gtlr_cfg_if.sink   cfg
);
  import gtlr_pkg::*;

  localparam int TW = $clog2(CAPACITY + 1);
  localparam int CW = (TW > CNT_OUT_W) ? TW : CNT_OUT_W;

  state_t               state, state_next;
  logic [CNT_OUT_W-1:0] max_tiles;
  logic [TW-1:0]        total, total_next;
  op_t                  op_q, op_next;
  logic                 src_q, src_next;
  logic [KEY_W-1:0]     skey, skey_next;
  logic [KEY_W-1:0]     tkey, tkey_next;
  logic                 hit_q, hit_next;
  logic                 insert_q, insert_next;
  logic                 move_q, move_next;
  logic [TW-1:0]        n_left, n_left_next;
  logic [TW-1:0]        rep, rep_next;
  logic                 out_v, out_v_next;
  rsp_t                 out_q, out_next;

  cell_ctl_t            ctl;
  logic [KEY_W-1:0]     chain_key [CAPACITY+1];
  logic                 sel_chain [CAPACITY+1];
  logic [KEY_W-1:0]     tail_key;
  logic [CW-1:0]        max_cw;
  logic [CW-1:0]        lim_cw;
  logic [TW-1:0]        lim;
  logic [TW:0]          after;
  logic                 slot_free;
  logic                 accept;

  assign max_cw    = CW'(max_tiles);
  assign lim_cw    = (max_cw < CW'(CAPACITY)) ? max_cw : CW'(CAPACITY);
  assign lim       = TW'(lim_cw);
  assign after     = {1'b0, total} + (TW+1)'(1);
  assign slot_free = !out_v || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;

  assign chain_key[0]        = skey;
  assign sel_chain[CAPACITY] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    gtlr_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .occupied   (TW'(i) < total),
      .search_key (skey),
      .key_in     (chain_key[i]),
      .sel_in     (sel_chain[i+1]),
      .key        (chain_key[i+1]),
      .sel_out    (sel_chain[i])
    );
  end

  // key of the least recently used resident tile
  always_comb begin
    tail_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tail_key = tail_key | (chain_key[i+1] & {KEY_W{TW'(i) == (total - TW'(1))}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      max_tiles <= MAX_TILES_RST;
      total     <= '0;
      out_v     <= 1'b0;
    end else begin
      state <= state_next;
      total <= total_next;
      out_v <= out_v_next;
      if (cfg.valid && cfg.ready) begin
        max_tiles <= cfg.max_tiles;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_q     <= op_next;
    src_q    <= src_next;
    skey     <= skey_next;
    tkey     <= tkey_next;
    hit_q    <= hit_next;
    insert_q <= insert_next;
    move_q   <= move_next;
    n_left   <= n_left_next;
    rep      <= rep_next;
    out_q    <= out_next;
  end

  always_comb begin
    state_next  = state;
    total_next  = total;
    op_next     = op_q;
    src_next    = src_q;
    skey_next   = skey;
    tkey_next   = tkey;
    hit_next    = hit_q;
    insert_next = insert_q;
    move_next   = move_q;
    n_left_next = n_left;
    rep_next    = rep;
    out_next    = out_q;
    out_v_next  = out_v && !rsp.ready;
    ctl         = '0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          op_next  = op_t'(req.operation);
          src_next = req.source_ok;
          case (op_t'(req.operation))
            OP_LOAD: begin
              skey_next  = tile_key_of(req.lat_deg, req.lon_deg);
              tkey_next  = skey_next;
              state_next = ST_SEARCH;
            end
            OP_LOOKUP: begin
              skey_next  = req.query_key;
              tkey_next  = req.query_key;
              state_next = ST_SEARCH;
            end
            OP_TRIM: begin
              tkey_next  = '0;
              state_next = ST_SEARCH;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end

      ST_SEARCH: begin
        ctl.mark_en = 1'b1;
        hit_next    = 1'b0;
        insert_next = 1'b0;
        move_next   = 1'b0;
        n_left_next = '0;
        rep_next    = '0;
        case (op_q)
          OP_LOAD: begin
            hit_next = sel_chain[0];
            if (sel_chain[0]) begin
              move_next = 1'b1;
            end else if (src_q && (lim == '0)) begin
              // the new tile would go at once: flush everything instead
              n_left_next = total;
              rep_next    = total - TW'(1);
            end else if (src_q) begin
              insert_next = 1'b1;
              n_left_next = (after > {1'b0, lim}) ? TW'(after - {1'b0, lim}) : '0;
              rep_next    = total;
            end
          end
          OP_LOOKUP: hit_next = sel_chain[0];
          default: begin
            n_left_next = (total > lim) ? (total - lim) : '0;
            rep_next    = total - TW'(1);
          end
        endcase
        state_next = (n_left_next != '0) ? ST_EVICT : ST_FINAL;
      end

      ST_EVICT: begin
        if (slot_free) begin
          out_v_next              = 1'b1;
          out_next.tile_key       = tkey;
          out_next.hit            = hit_q;
          out_next.stored         = insert_q;
          out_next.evicted_valid  = 1'b1;
          out_next.evicted_key    = tail_key;
          out_next.resident_count = CNT_OUT_W'(CW'(rep));
          out_next.last           = (n_left == TW'(1));
          rep_next                = rep - TW'(1);
          n_left_next             = n_left - TW'(1);
          total_next              = total - TW'(1);
          if (n_left == TW'(1)) begin
            state_next = ST_IDLE;
            if (insert_q) begin
              // tail read above comes from the registers before this shift
              ctl.shift     = 1'b1;
              ctl.shift_all = 1'b1;
              total_next    = total;
            end
          end
        end
      end

      ST_FINAL: begin
        if (slot_free) begin
          out_v_next              = 1'b1;
          out_next.tile_key       = tkey;
          out_next.hit            = hit_q;
          out_next.stored         = insert_q;
          out_next.evicted_valid  = 1'b0;
          out_next.evicted_key    = '0;
          out_next.resident_count = CNT_OUT_W'(CW'(total + TW'(insert_q)));
          out_next.last           = 1'b1;
          ctl.shift               = move_q || insert_q;
          ctl.shift_all           = insert_q;
          if (insert_q) begin
            total_next = total + TW'(1);
          end
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  assign rsp.valid          = out_v;
  assign rsp.tile_key       = out_q.tile_key;
  assign rsp.hit            = out_q.hit;
  assign rsp.stored         = out_q.stored;
  assign rsp.evicted_valid  = out_q.evicted_valid;
  assign rsp.evicted_key    = out_q.evicted_key;
  assign rsp.resident_count = out_q.resident_count;
  assign rsp.last           = out_q.last;

`ifndef SYNTH
  a_total_cap: assert property (@(posedge clk) disable iff (rst)
    total <= TW'(CAPACITY))
    else $error("resident count above capacity");

  a_evict_dec: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVICT && slot_free && n_left != TW'(1)) |=> total == $past(total) - TW'(1))
    else $error("eviction beat did not drop the resident count");

  a_plain_last: assert property (@(posedge clk) disable iff (rst)
    (out_v && !out_q.evicted_valid) |-> out_q.last)
    else $error("non-eviction beat not marked last");

  a_hit_stored: assert property (@(posedge clk) disable iff (rst)
    out_v |-> !(out_q.hit && out_q.stored))
    else $error("beat reports both hit and stored");
`endif

endmodule

@@ rtl/core/gtlr_cell.sv @@
`timescale 1ns / 1ps
// one slot of the recency chain: holds a key, compares it, shifts from its left neighbour
// depends on gtlr_pkg

module gtlr_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  gtlr_pkg::cell_ctl_t        ctl,
  input  logic                       occupied,
  input  logic [gtlr_pkg::KEY_W-1:0] search_key,
  input  logic [gtlr_pkg::KEY_W-1:0] key_in,
  input  logic                       sel_in,
  output logic [gtlr_pkg::KEY_W-1:0] key,
  output logic                       sel_out
);
  import gtlr_pkg::*;

  logic [KEY_W-1:0] key_q;
  logic             mark;
  logic             match;

  assign match   = occupied && (key_q == search_key);
  // set when the matching slot is here or further towards the tail
  assign sel_out = sel_in || match;
  assign key     = key_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      mark <= 1'b0;
    end else if (ctl.mark_en) begin
      mark <= sel_out;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift && (mark || ctl.shift_all)) begin
      key_q <= key_in;
    end
  end

endmodule
